FILE: design/cic_pkg.sv
// ----------------------------------------------------------------------------
// cic_pkg: shared definitions for the column iso-level crossing core
// Widths, register indexes, controller states and the command and status
// groups that pass between the controller and the datapath.
// ----------------------------------------------------------------------------
package cic_pkg;

	// default sample and coordinate width (Q16.16)
	localparam int VALUE_WIDTH_DEF = 32;

	// configuration register indexes
	localparam int CFG_IDX_W = 2;
	localparam logic [CFG_IDX_W-1:0] REG_ISO_VALUE     = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_MISSING_VALUE = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_CHECK_MISSING = 2'd2;

	// controller states
	typedef enum logic [2:0] {
		ST_IDLE,
		ST_MUL,
		ST_DIV,
		ST_RND,
		ST_PUSH
	} state_t;

	// controller to datapath
	typedef struct packed {
		logic take;      // input transfer this cycle
		logic mul_step;  // one shift-add step of the product
		logic div_step;  // one restoring division step
		logic rnd;       // round quotient and write the crossing
		logic push;      // load the output register, clear the column
	} cmd_t;

	// datapath to controller
	typedef struct packed {
		logic interp;    // the item being taken needs an interpolation
		logic cnt_zero;  // step counter at its final step
		logic last_q;    // the interpolated item closed its column
	} status_t;

endpackage

FILE: design/cic_ctrl.sv
// ----------------------------------------------------------------------------
// cic_ctrl: sequencing controller
// Takes input items, runs the multiply and divide phases of an
// interpolation and hands the column result to the output register.
// ----------------------------------------------------------------------------
module cic_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	input  logic              last_level,
	output logic              out_valid,
	input  logic              out_ready,
	input  cic_pkg::status_t  st,
	output cic_pkg::cmd_t     cmd
);

	cic_pkg::state_t state_q;
	cic_pkg::state_t state_nx;
	logic            out_valid_q;
	logic            slot_free;

	// output register can take a new result
	assign slot_free = !out_valid_q || out_ready;
	assign out_valid = out_valid_q;

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= cic_pkg::ST_IDLE;
		end else begin
			state_q <= state_nx;
		end
	end

	// output valid flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.push) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	// next state
	always_comb begin
		state_nx = state_q;
		unique case (state_q)
			cic_pkg::ST_IDLE: begin
				if (in_valid) begin
					if (st.interp) begin
						state_nx = cic_pkg::ST_MUL;
					end else if (last_level) begin
						state_nx = cic_pkg::ST_PUSH;
					end
				end
			end
			cic_pkg::ST_MUL: begin
				if (st.cnt_zero) begin
					state_nx = cic_pkg::ST_DIV;
				end
			end
			cic_pkg::ST_DIV: begin
				if (st.cnt_zero) begin
					state_nx = cic_pkg::ST_RND;
				end
			end
			cic_pkg::ST_RND: begin
				state_nx = st.last_q ? cic_pkg::ST_PUSH : cic_pkg::ST_IDLE;
			end
			cic_pkg::ST_PUSH: begin
				if (slot_free) begin
					state_nx = cic_pkg::ST_IDLE;
				end
			end
			default: state_nx = cic_pkg::ST_IDLE;
		endcase
	end

	// commands
	always_comb begin
		in_ready     = (state_q == cic_pkg::ST_IDLE);
		cmd.take     = in_valid && (state_q == cic_pkg::ST_IDLE);
		cmd.mul_step = (state_q == cic_pkg::ST_MUL);
		cmd.div_step = (state_q == cic_pkg::ST_DIV);
		cmd.rnd      = (state_q == cic_pkg::ST_RND);
		cmd.push     = (state_q == cic_pkg::ST_PUSH) && slot_free;
	end

endmodule

FILE: design/cic_datapath.sv
// ----------------------------------------------------------------------------
// cic_datapath: pair tests, column state and the interpolation unit
// Compares each new level with the previous one, keeps the column result
// and forms round(dl * dn / dd) with a shift-add multiplier followed by a
// restoring divider, one bit per cycle each.
// ----------------------------------------------------------------------------
module cic_datapath #(
	parameter int VALUE_WIDTH = cic_pkg::VALUE_WIDTH_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  cic_pkg::cmd_t                 cmd,
	input  logic signed [VALUE_WIDTH-1:0] sample_value,
	input  logic signed [VALUE_WIDTH-1:0] level_coord,
	input  logic                          last_level,
	input  logic                          cfg_valid,
	input  logic [cic_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [VALUE_WIDTH-1:0]        cfg_data,
	output cic_pkg::status_t              st,
	output logic signed [VALUE_WIDTH-1:0] crossing_coord,
	output logic                          result_missing
);

	localparam int W  = VALUE_WIDTH;
	localparam int CW = $clog2(W);
	localparam logic [CW-1:0] CNT_LAST = CW'(W - 1);

	// configuration
	logic signed [W-1:0] iso_q;
	logic signed [W-1:0] miss_q;
	logic                chk_q;

	// column state
	logic signed [W-1:0] prev_value_q;
	logic signed [W-1:0] prev_coord_q;
	logic                have_prev_q;
	logic                found_q;
	logic signed [W-1:0] held_q;
	logic                last_q;

	// interpolation unit
	logic [W-1:0]        mcand_q;
	logic [W-1:0]        mplier_q;
	logic [W-1:0]        dvsr_q;
	logic signed [W-1:0] base_q;
	logic                neg_q;
	logic [W-1:0]        acc_hi_q;
	logic [W-1:0]        acc_lo_q;
	logic [CW-1:0]       cnt_q;

	// output register
	logic signed [W-1:0] out_coord_q;
	logic                out_miss_q;

	// pair evaluation
	logic                m1;
	logic                m2;
	logic                skip;
	logic                bracket;
	logic                interp;
	logic signed [W-1:0] held_nx;
	logic                found_nx;
	logic [W-1:0]        dl;
	logic [W-1:0]        dn;
	logic [W-1:0]        dd;
	logic                neg;

	// step arithmetic
	logic [W:0]   mul_sum;
	logic [W:0]   div_t;
	logic         div_ge;
	logic [W:0]   div_sub;
	logic         rnd_up;
	logic [W-1:0] quot;

	function automatic logic [W-1:0] abs_diff(
		input logic signed [W-1:0] a,
		input logic signed [W-1:0] b
	);
		logic signed [W:0] d;
		d = {a[W-1], a} - {b[W-1], b};
		if (d[W]) begin
			d = -d;
		end
		return d[W-1:0];
	endfunction

	// missing and bracket tests on the previous and current level
	always_comb begin
		m1 = chk_q && (prev_value_q == miss_q);
		m2 = chk_q && (sample_value == miss_q);
		skip = m1 || m2;
		bracket = have_prev_q && !found_q && !skip &&
			((iso_q >= prev_value_q && iso_q <= sample_value) ||
			 (iso_q >= sample_value && iso_q <= prev_value_q));
		interp = bracket && (prev_value_q != sample_value);
		dl  = abs_diff(level_coord, prev_coord_q);
		dn  = abs_diff(iso_q, prev_value_q);
		dd  = abs_diff(sample_value, prev_value_q);
		neg = (level_coord < prev_coord_q) ^ (iso_q < prev_value_q) ^
			(sample_value < prev_value_q);
	end

	// column result after this level
	always_comb begin
		held_nx  = held_q;
		found_nx = found_q;
		if (!have_prev_q) begin
			held_nx  = miss_q;
			found_nx = 1'b0;
		end else if (!found_q) begin
			// exact match next to a missing sample is provisional
			if (m1 && !m2 && (iso_q == sample_value)) begin
				held_nx = level_coord;
			end
			if (m2 && !m1 && (iso_q == prev_value_q)) begin
				held_nx = prev_coord_q;
			end
			if (bracket) begin
				found_nx = 1'b1;
				if (!interp) begin
					held_nx = prev_coord_q;
				end
			end
		end
	end

	// multiply, divide and rounding steps
	always_comb begin
		mul_sum = {1'b0, acc_hi_q} + (mplier_q[0] ? {1'b0, mcand_q} : '0);
		div_t   = {acc_hi_q, acc_lo_q[W-1]};
		div_ge  = (div_t >= {1'b0, dvsr_q});
		div_sub = div_t - {1'b0, dvsr_q};
		rnd_up  = ({acc_hi_q, 1'b0} >= {1'b0, dvsr_q});
		quot    = acc_lo_q + W'(rnd_up);
	end

	assign st.interp   = interp;
	assign st.cnt_zero = (cnt_q == '0);
	assign st.last_q   = last_q;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			iso_q  <= '0;
			miss_q <= '0;
			chk_q  <= 1'b0;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				cic_pkg::REG_ISO_VALUE:     iso_q  <= cfg_data;
				cic_pkg::REG_MISSING_VALUE: miss_q <= cfg_data;
				cic_pkg::REG_CHECK_MISSING: chk_q  <= cfg_data[0];
				default: ;
			endcase
		end
	end

	// column control flags
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			have_prev_q <= 1'b0;
			found_q     <= 1'b0;
		end else if (cmd.take) begin
			have_prev_q <= 1'b1;
			found_q     <= found_nx;
		end else if (cmd.push) begin
			have_prev_q <= 1'b0;
			found_q     <= 1'b0;
		end
	end

	// column payload and held result
	always_ff @(posedge clk) begin
		if (cmd.take) begin
			prev_value_q <= sample_value;
			prev_coord_q <= level_coord;
			held_q       <= held_nx;
			last_q       <= last_level;
		end else if (cmd.rnd) begin
			held_q <= neg_q ? (base_q - $signed(quot)) : (base_q + $signed(quot));
		end
	end

	// interpolation unit
	always_ff @(posedge clk) begin
		if (cmd.take) begin
			mcand_q  <= dl;
			mplier_q <= dn;
			dvsr_q   <= dd;
			base_q   <= prev_coord_q;
			neg_q    <= neg;
			acc_hi_q <= '0;
			acc_lo_q <= '0;
			cnt_q    <= CNT_LAST;
		end else if (cmd.mul_step) begin
			acc_hi_q <= mul_sum[W:1];
			acc_lo_q <= {mul_sum[0], acc_lo_q[W-1:1]};
			mplier_q <= mplier_q >> 1;
			cnt_q    <= (cnt_q == '0) ? CNT_LAST : cnt_q - 1'b1;
		end else if (cmd.div_step) begin
			acc_hi_q <= div_ge ? div_sub[W-1:0] : div_t[W-1:0];
			acc_lo_q <= {acc_lo_q[W-2:0], div_ge};
			cnt_q    <= cnt_q - 1'b1;
		end
	end

	// output register
	always_ff @(posedge clk) begin
		if (cmd.push) begin
			out_coord_q <= held_q;
			out_miss_q  <= (held_q == miss_q);
		end
	end

	assign crossing_coord = out_coord_q;
	assign result_missing = out_miss_q;

endmodule

FILE: design/column_isolevel_crossing_core.sv
// ----------------------------------------------------------------------------
// column_isolevel_crossing_core: iso-level crossing of a vertical column
// Finds where a column of Q16.16 samples first crosses an iso value, by
// linear interpolation between neighbouring levels.
// ----------------------------------------------------------------------------
// Usage:
//  - levels arrive on the input channel (in_valid/in_ready), top index first;
//    last_level marks the final level, and one result per column leaves on
//    the output channel (out_valid/out_ready)
//  - configuration writes use cfg_valid/cfg_index/cfg_data, cfg_ready is
//    always high; index 0 iso value, 1 missing value, 2 missing check enable
//  - a level with no interpolation is taken in the idle state and passes push
//    if it closes its column; the level that brackets the crossing (at most once
//    per column) runs the multiply, divide and round states, and push if it closes
//    the column, in the one-bit-a-cycle shift-add multiplier and restoring divider
//  - the result enters the output register in the push state, which follows the
//    closing level (or the round step) and waits while the output register is full
//  - while a result waits for out_ready, input levels are still taken; only
//    a column end that finds the output register full waits for it
//  - reset clears the configuration to zero, the column control flags and the
//    output valid flag
// ----------------------------------------------------------------------------
module column_isolevel_crossing_core #(
	parameter int VALUE_WIDTH = cic_pkg::VALUE_WIDTH_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_ready,
	input  logic signed [VALUE_WIDTH-1:0] sample_value,
	input  logic signed [VALUE_WIDTH-1:0] level_coord,
	input  logic                          last_level,
	output logic                          out_valid,
	input  logic                          out_ready,
	output logic signed [VALUE_WIDTH-1:0] crossing_coord,
	output logic                          result_missing,
	input  logic                          cfg_valid,
	output logic                          cfg_ready,
	input  logic [cic_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [VALUE_WIDTH-1:0]        cfg_data
);

	cic_pkg::cmd_t    cmd;
	cic_pkg::status_t st;

	// configuration transfers are taken at any time
	assign cfg_ready = 1'b1;

	cic_ctrl u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.last_level (last_level),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.st         (st),
		.cmd        (cmd)
	);

	cic_datapath #(
		.VALUE_WIDTH (VALUE_WIDTH)
	) u_datapath (
		.clk            (clk),
		.arst_n         (arst_n),
		.cmd            (cmd),
		.sample_value   (sample_value),
		.level_coord    (level_coord),
		.last_level     (last_level),
		.cfg_valid      (cfg_valid),
		.cfg_index      (cfg_index),
		.cfg_data       (cfg_data),
		.st             (st),
		.crossing_coord (crossing_coord),
		.result_missing (result_missing)
	);

endmodule
